// File: sv/vbf_pkg.sv
// Package for the voxel blend framebuffer: sizes, codes, queue item and status types.
// Used by the interfaces, the front, queue and back stages and the top level.
// Depends on nothing.
package vbf_pkg;

  // Cube geometry; SIDE may range from 2 to 8.
  localparam int SIDE      = 8;
  localparam int VOXELS    = SIDE * SIDE * SIDE;
  localparam int CHAN      = 3;
  localparam int ENTRIES   = VOXELS * CHAN;
  localparam int FRAME_LEN = ENTRIES + 4;
  localparam int ROW_AW    = $clog2(VOXELS);
  localparam int CH_W      = $clog2(CHAN);

  // Field widths.
  localparam int MODE_W    = 2;
  localparam int COORD_W   = 5;
  localparam int LEVEL_W   = 16;
  localparam int IDX_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COMMAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CHANNEL = 2'd1;

  // Frame header length bytes.
  localparam logic [BYTE_W-1:0] HDR_LEN_HI = BYTE_W'((ENTRIES >> 8) & 255);
  localparam logic [BYTE_W-1:0] HDR_LEN_LO = BYTE_W'(ENTRIES & 255);

  // floor(e/3) = (e * RECIP3) >> 16, exact for any 11-bit e.
  localparam int RECIP3 = 21846;
  // floor(v/257) = (v * RECIP257) >> 24, exact for any 16-bit v.
  localparam int RECIP257 = 65281;

  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(VOXELS - 1);

  typedef logic [CHAN-1:0][LEVEL_W-1:0] vbf_rgb_t;

  typedef enum logic [2:0] {
    OP_SET,
    OP_BLEND,
    OP_FILL,
    OP_HDR,
    OP_VOX
  } vbf_op_e;

  // One classified operation as it travels from the front to the back.
  typedef struct packed {
    vbf_op_e             op;
    logic [ROW_AW-1:0]   row;
    logic [CH_W-1:0]     chan;
    vbf_rgb_t            color;
    logic [LEVEL_W-1:0]  weight;
    logic [BYTE_W-1:0]   hdr_byte;
    logic                last;
  } vbf_item_t;

  typedef struct packed {
    logic clearing;
    logic filling;
  } vbf_back_st_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_BL_MUL,
    ST_BL_ADD,
    ST_WR,
    ST_RD_DIV,
    ST_OUT
  } vbf_state_e;

endpackage

// File: sv/vbf_if.sv
// Channel interfaces of the voxel blend framebuffer: item input, frame byte output,
// and configuration writes. Depends on vbf_pkg.
interface vbf_in_if import vbf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;
  logic [LEVEL_W-1:0]         red_level;
  logic [LEVEL_W-1:0]         green_level;
  logic [LEVEL_W-1:0]         blue_level;
  logic [LEVEL_W-1:0]         blend_weight;
  logic [IDX_W-1:0]           byte_index;

  modport source (
    output valid, mode, coord_x, coord_y, coord_z, red_level, green_level,
           blue_level, blend_weight, byte_index,
    input  ready
  );
  modport sink (
    input  valid, mode, coord_x, coord_y, coord_z, red_level, green_level,
           blue_level, blend_weight, byte_index,
    output ready
  );
endinterface

interface vbf_out_if import vbf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface vbf_cfg_if import vbf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/voxel_blend_framebuffer.sv
// Top level of the voxel blend framebuffer: front stage, operation queue, back
// stage and voxel memory. Depends on vbf_pkg, the channel interfaces and all submodules.
//
// The block holds a SIDE x SIDE x SIDE cube of voxels, three 16-bit color channels
// each, in one memory row per voxel. After reset a clearing pass writes zero to
// every row, one row a cycle; no transaction is accepted on the item channel
// during that pass, while configuration writes are taken at all times. Each item
// is accepted by the front stage, which checks coordinates, resolves frame header
// bytes and splits a frame index into voxel row and channel; set and blend items
// outside the cube are dropped there. Up to two operations wait in a queue for
// the back stage, which owns the single write port and single read port of the
// voxel memory and therefore sets the rate: a set runs its write state, a frame
// byte read a divide state and then the output state (header bytes the output
// state alone), a blend one read, then a multiply step and a divide-by-65535 step
// per channel, then the write, and a fill one write to every row. A finished
// frame byte sits in an output register, so the back stage starts the next
// operation while that transaction is still waiting.
module voxel_blend_framebuffer import vbf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  vbf_cfg_if.sink  cfg_i,
  vbf_in_if.sink   in_i,
  vbf_out_if.source res_o
);

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  vbf_item_t         item;
  vbf_item_t         head;
  vbf_back_st_t      back_st;
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_AW-1:0] ram_raddr;
  vbf_rgb_t          ram_wdata;
  vbf_rgb_t          ram_rdata;

  // The front is held off until the clearing pass is done.
  vbf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_i),
    .cfg_chan (cfg_i),
    .enable_i (!back_st.clearing),
    .full_i   (full),
    .push_o   (push),
    .item_o   (item)
  );

  vbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  vbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res         (res_o),
    .status_o    (back_st)
  );

  // One row per voxel; channel c of the row is bits [16c +: 16].
  vbf_ram #(
    .WIDTH (CHAN * LEVEL_W),
    .DEPTH (VOXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // No frame byte can be offered before the cube has been cleared.
  a_no_result_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) back_st.clearing |-> !res_o.valid
  ) else $error("frame byte offered during the clearing pass");

  // The clearing pass writes only zero.
  a_clear_writes_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (back_st.clearing && ram_we) |-> (ram_wdata == '0)
  ) else $error("clearing pass wrote a nonzero row");

  // The clearing pass ends only after the last row has been written.
  a_clear_covers_all_rows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $fell(back_st.clearing) |-> ($past(ram_waddr) == ROW_LAST)
  ) else $error("clearing pass ended before the last row");

  // A fill writes a row in every cycle it runs.
  a_fill_writes: assert property (
    @(posedge clk_i) disable iff (!rst_ni) back_st.filling |-> ram_we
  ) else $error("fill cycle without a memory write");

endmodule

// File: sv/vbf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module vbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/vbf_front.sv
// Front stage: holds the frame header registers, accepts items and turns each one
// into a queue operation. Depends on vbf_pkg and the channel interfaces.
module vbf_front import vbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vbf_in_if.sink     in_chan,
  vbf_cfg_if.sink    cfg_chan,
  input  logic       enable_i,
  input  logic       full_i,
  output logic       push_o,
  output vbf_item_t  item_o
);

  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [BYTE_W-1:0] chn_q, chn_d;
  logic              keep;
  logic              x_ok, y_ok, z_ok;
  logic [IDX_W-1:0]  entry;
  logic [31:0]       div_prod;
  logic [IDX_W-1:0]  quot;
  logic [IDX_W-1:0]  rem;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cmd_d = cmd_q;
    chn_d = chn_q;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_FRAME_COMMAND: cmd_d = cfg_chan.data;
        CFG_FRAME_CHANNEL: chn_d = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
      chn_q <= '0;
    end else begin
      cmd_q <= cmd_d;
      chn_q <= chn_d;
    end
  end

  // A coordinate is usable when it is non-negative and below SIDE.
  assign x_ok = !in_chan.coord_x[COORD_W-1] && (unsigned'(in_chan.coord_x) < COORD_W'(SIDE));
  assign y_ok = !in_chan.coord_y[COORD_W-1] && (unsigned'(in_chan.coord_y) < COORD_W'(SIDE));
  assign z_ok = !in_chan.coord_z[COORD_W-1] && (unsigned'(in_chan.coord_z) < COORD_W'(SIDE));

  // Frame entry split into voxel row and channel.
  assign entry    = in_chan.byte_index - IDX_W'(4);
  assign div_prod = 32'(entry) * 32'(RECIP3);
  assign quot     = IDX_W'(div_prod >> 16);
  assign rem      = entry - (quot + (quot << 1));

  always_comb begin
    item_o.op       = OP_HDR;
    item_o.row      = ROW_AW'((int'(unsigned'(in_chan.coord_x[COORD_W-2:0])) * SIDE
                      + int'(unsigned'(in_chan.coord_y[COORD_W-2:0]))) * SIDE
                      + int'(unsigned'(in_chan.coord_z[COORD_W-2:0])));
    item_o.chan     = rem[CH_W-1:0];
    item_o.color[0] = in_chan.red_level;
    item_o.color[1] = in_chan.green_level;
    item_o.color[2] = in_chan.blue_level;
    item_o.weight   = in_chan.blend_weight;
    item_o.hdr_byte = '0;
    item_o.last     = (32'(in_chan.byte_index) == 32'(FRAME_LEN - 1));
    keep            = 1'b1;
    case (in_chan.mode)
      MODE_SET: begin
        item_o.op = OP_SET;
        keep      = x_ok && y_ok && z_ok;
      end
      MODE_BLEND: begin
        item_o.op = OP_BLEND;
        keep      = x_ok && y_ok && z_ok;
      end
      MODE_FILL: begin
        item_o.op = OP_FILL;
      end
      MODE_READ: begin
        case (in_chan.byte_index)
          IDX_W'(0): item_o.hdr_byte = cmd_q;
          IDX_W'(1): item_o.hdr_byte = chn_q;
          IDX_W'(2): item_o.hdr_byte = HDR_LEN_HI;
          IDX_W'(3): item_o.hdr_byte = HDR_LEN_LO;
          default: begin
            if (32'(in_chan.byte_index) < 32'(FRAME_LEN)) begin
              item_o.op  = OP_VOX;
              item_o.row = ROW_AW'(quot);
            end
          end
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_chan.ready = enable_i && !full_i;
  assign push_o        = in_chan.valid && in_chan.ready && keep;

endmodule

// File: sv/vbf_queue.sv
// Short queue of classified operations between the front and back stages.
// Depends on vbf_pkg.
module vbf_queue import vbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  vbf_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output vbf_item_t head_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  vbf_item_t       slot_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

// File: sv/vbf_back.sv
// Back stage: sequencer that clears and fills the voxel memory, runs set and blend
// writes, reads frame bytes and holds the output register. Depends on vbf_pkg.
module vbf_back import vbf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  vbf_item_t                 head_i,
  output logic                      pop_o,
  output logic                      ram_we_o,
  output logic [ROW_AW-1:0]         ram_waddr_o,
  output vbf_rgb_t                  ram_wdata_o,
  output logic [ROW_AW-1:0]         ram_raddr_o,
  input  vbf_rgb_t                  ram_rdata_i,
  vbf_out_if.source                 res,
  output vbf_back_st_t              status_o
);

  vbf_state_e         state_q, state_d;
  logic [ROW_AW-1:0]  fill_q, fill_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  vbf_item_t          item_q;
  vbf_rgb_t           new_q;
  logic [31:0]        pa_q, pb_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               out_last_q;
  logic [32:0]        blend_sum;
  logic [32:0]        blend_rnd;
  logic [31:0]        rd_prod;

  // floor(n / 65535) for n <= 65535^2 is (n + (n >> 16) + 1) >> 16.
  assign blend_sum = 33'(pa_q) + 33'(pb_q);
  assign blend_rnd = blend_sum + (blend_sum >> 16) + 33'd1;
  assign rd_prod   = 32'(ram_rdata_i[item_q.chan]) * 32'(RECIP257);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ch_d        = ch_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = fill_q;
    ram_wdata_o = '0;
    ram_raddr_o = item_q.row;
    case (state_q)
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        if (fill_q == ROW_LAST) begin
          fill_d  = '0;
          state_d = ST_IDLE;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_raddr_o = head_i.row;
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_SET:   state_d = ST_WR;
            OP_BLEND: begin
              ch_d    = '0;
              state_d = ST_BL_MUL;
            end
            OP_FILL: begin
              fill_d  = '0;
              state_d = ST_FILL;
            end
            OP_VOX:   state_d = ST_RD_DIV;
            OP_HDR:   state_d = ST_OUT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = item_q.color;
        if (fill_q == ROW_LAST) begin
          fill_d  = '0;
          state_d = ST_IDLE;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      ST_BL_MUL: state_d = ST_BL_ADD;
      ST_BL_ADD: begin
        if (ch_q == CH_W'(CHAN - 1)) begin
          ch_d    = '0;
          state_d = ST_WR;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_BL_MUL;
        end
      end
      ST_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = item_q.row;
        ram_wdata_o = new_q;
        state_d     = ST_IDLE;
      end
      ST_RD_DIV: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || res.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      fill_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
      new_q  <= head_i.color;
      byte_q <= head_i.hdr_byte;
    end
    if (state_q == ST_BL_MUL) begin
      pa_q <= 32'(ram_rdata_i[ch_q]) * 32'(16'hFFFF - item_q.weight);
      pb_q <= 32'(item_q.color[ch_q]) * 32'(item_q.weight);
    end
    if (state_q == ST_BL_ADD) begin
      new_q[ch_q] <= blend_rnd[31:16];
    end
    if (state_q == ST_RD_DIV) begin
      byte_q <= rd_prod[31:24];
    end
    if (out_load) begin
      out_byte_q <= byte_q;
      out_last_q <= item_q.last;
    end
  end

  assign res.valid      = out_valid_q;
  assign res.frame_byte = out_byte_q;
  assign res.last_byte  = out_last_q;

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.filling  = (state_q == ST_FILL);

endmodule

// File: verif/vbf_checker.sv
// Checker for the voxel blend framebuffer: watches the configuration, item and frame byte
// channels, keeps its own copy of the cube, and compares every frame byte in order.
// Depends on vbf_pkg and the channel interfaces in vbf_if.sv.
module vbf_checker import vbf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  vbf_cfg_if   cfg_mon,
  vbf_in_if    item_mon,
  vbf_out_if   frame_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } frame_byte_t;

  logic [LEVEL_W-1:0] shadow_voxels [ENTRIES];
  logic [BYTE_W-1:0]  shadow_command;
  logic [BYTE_W-1:0]  shadow_channel;
  frame_byte_t        expected_bytes [$];
  int                 fail_count;

  function automatic logic [LEVEL_W-1:0] blend_level(input logic [LEVEL_W-1:0] old_level,
                                                     input logic [LEVEL_W-1:0] color,
                                                     input logic [LEVEL_W-1:0] weight);
    logic [33:0] mix;
    mix = 34'(old_level) * 34'(16'hFFFF - weight) + 34'(color) * 34'(weight);
    return LEVEL_W'(mix / 34'd65535);
  endfunction

  function automatic bit in_cube(input logic signed [COORD_W-1:0] coord);
    return coord >= 0 && coord < SIDE;
  endfunction

  function automatic frame_byte_t frame_byte_at(input logic [IDX_W-1:0] idx);
    frame_byte_t fb;
    int          pos;
    pos = int'(idx);
    fb.byte_index = idx;
    fb.last_byte  = (pos == FRAME_LEN - 1);
    if (pos == 0) begin
      fb.frame_byte = shadow_command;
    end else if (pos == 1) begin
      fb.frame_byte = shadow_channel;
    end else if (pos == 2) begin
      fb.frame_byte = BYTE_W'(ENTRIES >> 8);
    end else if (pos == 3) begin
      fb.frame_byte = BYTE_W'(ENTRIES);
    end else if (pos < FRAME_LEN) begin
      fb.frame_byte = BYTE_W'(shadow_voxels[pos-4] / 16'd257);
    end else begin
      fb.frame_byte = '0;
    end
    return fb;
  endfunction

  task automatic flag_failure(input string detail);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", detail);
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk_i) begin
    int                 base;
    logic [LEVEL_W-1:0] color [CHAN];
    frame_byte_t        got;
    frame_byte_t        want;
    if (!rst_ni) begin
      foreach (shadow_voxels[i]) shadow_voxels[i] = '0;
      shadow_command = '0;
      shadow_channel = '0;
      expected_bytes.delete();
    end else begin
      // Register writes must land only while the block is idle; the user, not the
      // block, sees to that. Applying them at once matches what later header reads see.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_FRAME_COMMAND: shadow_command = cfg_mon.data;
          CFG_FRAME_CHANNEL: shadow_channel = cfg_mon.data;
          default: ;
        endcase
      end

      if (item_mon.valid && item_mon.ready) begin
        color[0] = item_mon.red_level;
        color[1] = item_mon.green_level;
        color[2] = item_mon.blue_level;
        case (item_mon.mode)
          MODE_FILL: begin
            foreach (shadow_voxels[i]) shadow_voxels[i] = color[i % CHAN];
          end
          MODE_READ: begin
            expected_bytes.push_back(frame_byte_at(item_mon.byte_index));
          end
          default: begin
            if (in_cube(item_mon.coord_x) && in_cube(item_mon.coord_y) &&
                in_cube(item_mon.coord_z)) begin
              base = ((int'(item_mon.coord_x) * SIDE + int'(item_mon.coord_y)) * SIDE +
                      int'(item_mon.coord_z)) * CHAN;
              for (int c = 0; c < CHAN; c++) begin
                if (item_mon.mode == MODE_SET) begin
                  shadow_voxels[base+c] = color[c];
                end else begin
                  shadow_voxels[base+c] = blend_level(shadow_voxels[base+c], color[c],
                                                      item_mon.blend_weight);
                end
              end
            end
          end
        endcase
      end

      if (frame_mon.valid && frame_mon.ready) begin
        got.byte_index = '0;
        got.frame_byte = frame_mon.frame_byte;
        got.last_byte  = frame_mon.last_byte;
        if (expected_bytes.size() == 0) begin
          flag_failure($sformatf("unexpected frame byte %0d last %0b", got.frame_byte,
                                 got.last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte) begin
            flag_failure($sformatf("frame byte %0d: expected %0d last %0b, got %0d last %0b",
                                   want.byte_index, want.frame_byte, want.last_byte,
                                   got.frame_byte, got.last_byte));
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_bytes.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for the voxel blend framebuffer: clock, reset, item and register stimulus,
// a randomly stalling frame byte receiver, a watchdog and the final verdict.
// Depends on vbf_pkg, the channel interfaces, the block itself and vbf_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vbf_pkg::*;

  // Random part: five phases with a register setting each.
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 190;
  // Chance in percent that a side idles in a given cycle.
  localparam int IDLE_PCT        = 23;
  // A fill writes every row and two more operations may wait behind the one
  // in progress, so this hold-off covers the deepest silent backlog.
  localparam int SETTLE_CYCLES   = 2000;
  // Cycles without any transaction before the run is declared hung. It must
  // exceed the clearing pass after reset and the hold-off above.
  localparam int WATCHDOG_LIMIT  = 20000;
  // Register indexes that the block does not implement; writes are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [LEVEL_W-1:0]        red;
    logic [LEVEL_W-1:0]        green;
    logic [LEVEL_W-1:0]        blue;
    logic [LEVEL_W-1:0]        weight;
    logic [IDX_W-1:0]          idx;
  } voxel_cmd_t;

  logic clk_i;
  logic rst_ni;
  // When set, neither the item sender nor the frame byte receiver idles.
  logic calm;
  int   fail_count;
  int   pending_bytes;
  int   quiet_cycles;
  int   focus_entry;

  vbf_cfg_if cfg_bus ();
  vbf_in_if  item_bus ();
  vbf_out_if frame_bus ();

  voxel_blend_framebuffer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (item_bus),
    .res_o  (frame_bus)
  );

  vbf_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .item_mon     (item_bus),
    .frame_mon    (frame_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes)
  );

  initial clk_i = 1'b0;
  always #1ns clk_i = ~clk_i;

  // The receiver stalls at random unless the calm stretch is on.
  always @(posedge clk_i) begin
    frame_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // The watchdog restarts its count on every transaction of any channel.
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (frame_bus.valid && frame_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("voxel_blend_framebuffer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A color level that hits both ends of the range often.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // Every field random; the builders below then fix the ones that matter, so
  // ignored fields still carry noise.
  function automatic voxel_cmd_t noise_cmd();
    voxel_cmd_t c;
    c.mode   = MODE_W'($urandom);
    c.x      = COORD_W'($urandom);
    c.y      = COORD_W'($urandom);
    c.z      = COORD_W'($urandom);
    c.red    = LEVEL_W'($urandom);
    c.green  = LEVEL_W'($urandom);
    c.blue   = LEVEL_W'($urandom);
    c.weight = LEVEL_W'($urandom);
    c.idx    = IDX_W'($urandom);
    return c;
  endfunction

  function automatic voxel_cmd_t read_cmd(input int idx);
    voxel_cmd_t c;
    c      = noise_cmd();
    c.mode = MODE_READ;
    c.idx  = IDX_W'(idx);
    return c;
  endfunction

  function automatic voxel_cmd_t write_cmd(input logic [MODE_W-1:0] mode,
                                           input int x, input int y, input int z,
                                           input logic [LEVEL_W-1:0] red,
                                           input logic [LEVEL_W-1:0] green,
                                           input logic [LEVEL_W-1:0] blue,
                                           input logic [LEVEL_W-1:0] weight);
    voxel_cmd_t c;
    c        = noise_cmd();
    c.mode   = mode;
    c.x      = COORD_W'(x);
    c.y      = COORD_W'(y);
    c.z      = COORD_W'(z);
    c.red    = red;
    c.green  = green;
    c.blue   = blue;
    c.weight = weight;
    return c;
  endfunction

  function automatic voxel_cmd_t fill_cmd(input logic [LEVEL_W-1:0] red,
                                          input logic [LEVEL_W-1:0] green,
                                          input logic [LEVEL_W-1:0] blue);
    voxel_cmd_t c;
    c       = noise_cmd();
    c.mode  = MODE_FILL;
    c.red   = red;
    c.green = green;
    c.blue  = blue;
    return c;
  endfunction

  // Presents one item and returns at the edge where it is taken. Valid stays
  // high afterwards so the next item can follow back to back; it is lowered
  // either by an idle cycle here or by settle_cube.
  task automatic send_cmd(input voxel_cmd_t c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid        <= 1'b1;
    item_bus.mode         <= c.mode;
    item_bus.coord_x      <= c.x;
    item_bus.coord_y      <= c.y;
    item_bus.coord_z      <= c.z;
    item_bus.red_level    <= c.red;
    item_bus.green_level  <= c.green;
    item_bus.blue_level   <= c.blue;
    item_bus.blend_weight <= c.weight;
    item_bus.byte_index   <= c.idx;
    do @(posedge clk_i); while (!item_bus.ready);
  endtask

  // Drops valid, waits for every outstanding frame byte, then lets the back
  // stage finish any fill or blend that produces nothing visible.
  task automatic settle_cube();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both frame header registers and pokes the two unused indexes,
  // whose writes must leave the header unchanged.
  task automatic program_header(input logic [BYTE_W-1:0] command,
                                input logic [BYTE_W-1:0] channel);
    logic [CFG_IDX_W-1:0] order [4];
    logic [BYTE_W-1:0]    value [4];
    order = '{CFG_SPARE_A, CFG_FRAME_COMMAND, CFG_SPARE_B, CFG_FRAME_CHANNEL};
    value = '{BYTE_W'($urandom), command, BYTE_W'($urandom), channel};
    for (int k = 0; k < 4; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= order[k];
      cfg_bus.data  <= value[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    voxel_cmd_t           c;
    int                   roll;
    int                   x;
    int                   y;
    int                   z;
    logic [MODE_W-1:0]    mode;
    // Every input starts at a known value before the first clock edge.
    rst_ni                = 1'b0;
    calm                  = 1'b0;
    quiet_cycles          = 0;
    focus_entry           = 0;
    item_bus.valid        = 1'b0;
    item_bus.mode         = MODE_SET;
    item_bus.coord_x      = '0;
    item_bus.coord_y      = '0;
    item_bus.coord_z      = '0;
    item_bus.red_level    = '0;
    item_bus.green_level  = '0;
    item_bus.blue_level   = '0;
    item_bus.blend_weight = '0;
    item_bus.byte_index   = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_FRAME_COMMAND;
    cfg_bus.data          = '0;
    frame_bus.ready       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The header is read with the registers still at their
    // reset values, then the cleared cube, the last byte of the frame and
    // indexes past its end, including the all-ones index.
    send_cmd(read_cmd(0));
    send_cmd(read_cmd(1));
    send_cmd(read_cmd(2));
    send_cmd(read_cmd(3));
    send_cmd(read_cmd(4));
    send_cmd(read_cmd(FRAME_LEN - 1));
    send_cmd(read_cmd(FRAME_LEN));
    send_cmd(read_cmd(IDX_MAX));
    // Corner voxels with extreme levels; the first is read back channel by channel.
    send_cmd(write_cmd(MODE_SET, 0, 0, 0, 16'hFFFF, 16'h0000, 16'h8000, '0));
    send_cmd(read_cmd(4));
    send_cmd(read_cmd(5));
    send_cmd(read_cmd(6));
    send_cmd(write_cmd(MODE_SET, SIDE - 1, SIDE - 1, SIDE - 1, 16'd1, 16'd257, 16'hFFFE,
                       '1));
    send_cmd(read_cmd(FRAME_LEN - 1));
    // Coordinates outside the cube on each axis, negative and too large; the
    // cube must not change.
    send_cmd(write_cmd(MODE_SET, -16, 0, 0, '1, '1, '1, '1));
    send_cmd(write_cmd(MODE_SET, 0, -1, 0, '1, '1, '1, '1));
    send_cmd(write_cmd(MODE_BLEND, 0, 0, SIDE, '1, '1, '1, '1));
    send_cmd(write_cmd(MODE_SET, 15, 15, 15, '1, '1, '1, '1));
    // Blends with zero weight (no change), full weight (plain replace) and half.
    send_cmd(write_cmd(MODE_BLEND, 0, 0, 0, pick_level(), pick_level(), pick_level(), '0));
    send_cmd(write_cmd(MODE_BLEND, 0, 0, 0, 16'h0000, 16'hFFFF, 16'h0001, '1));
    send_cmd(write_cmd(MODE_BLEND, SIDE - 1, SIDE - 1, SIDE - 1, pick_level(), pick_level(),
                       pick_level(), 16'h8000));
    send_cmd(read_cmd(4));
    send_cmd(read_cmd(5));
    send_cmd(read_cmd(FRAME_LEN - 3));
    // A fill overwrites everything, including the corners written above.
    send_cmd(fill_cmd(pick_level(), pick_level(), pick_level()));
    send_cmd(read_cmd($urandom_range(FRAME_LEN - 1, 4)));
    settle_cube();

    // Random phases. Each one starts from an idle block with a new header
    // setting; the first and last use the register extremes.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       program_header(8'hFF, 8'h00);
        1:       program_header(8'h00, 8'hFF);
        PHASES - 1: program_header(8'hFF, 8'hFF);
        default: program_header(BYTE_W'($urandom), BYTE_W'($urandom));
      endcase
      // One phase runs without any idling on either side.
      calm <= (phase == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 1) begin
          c = fill_cmd(pick_level(), pick_level(), pick_level());
        end else if (roll < 7) begin
          // Noise: coordinates over the full signed range, mostly off the cube.
          mode = ($urandom_range(1) == 0) ? MODE_SET : MODE_BLEND;
          c = write_cmd(mode, $urandom, $urandom, $urandom, pick_level(), pick_level(),
                        pick_level(), pick_level());
        end else if (roll < 60) begin
          // Write inside the cube and make that voxel the target of the
          // frame byte reads that follow.
          mode = (roll < 35) ? MODE_SET : MODE_BLEND;
          x = $urandom_range(SIDE - 1);
          y = $urandom_range(SIDE - 1);
          z = $urandom_range(SIDE - 1);
          focus_entry = ((x * SIDE + y) * SIDE + z) * CHAN;
          c = write_cmd(mode, x, y, z, pick_level(), pick_level(), pick_level(),
                        pick_level());
        end else if (roll < 85) begin
          c = read_cmd(focus_entry + 4 + $urandom_range(CHAN - 1));
        end else if (roll < 95) begin
          c = read_cmd($urandom_range(FRAME_LEN - 1));
        end else begin
          c = read_cmd($urandom_range(IDX_MAX));
        end
        send_cmd(c);
      end
      // The sender holds off until every frame byte of the phase is back.
      settle_cube();
      calm <= 1'b0;
    end

    if (fail_count == 0 && pending_bytes == 0) begin
      $display("voxel_blend_framebuffer: match");
    end else begin
      $display("voxel_blend_framebuffer: mismatch");
    end
    $finish;
  end

endmodule
